>>> src/fqc_pkg.sv
`timescale 1ns / 1ps

package fqc_pkg;

  // default queue depth
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int CMD_W       = 3;
  localparam int DATA_W      = 32;
  localparam int ST_W        = 2;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // sequencer to walk unit
  typedef struct packed {
    logic start;    // load pointers from head and count
    logic rd_step;  // issue one read and advance
    logic cancel;   // compare read data and compact survivors
  } walk_ctl_t;

endpackage

>>> src/fqc_ram.sv
`timescale 1ns / 1ps

module fqc_ram #(
  parameter int DEPTH = fqc_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [fqc_pkg::DATA_W-1:0]          wdata,
  input  logic                                re,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [fqc_pkg::DATA_W-1:0]          rdata
);
  import fqc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/fqc_walk.sv
`timescale 1ns / 1ps

module fqc_walk #(
  parameter int DEPTH = fqc_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fqc_pkg::walk_ctl_t               ctl,
  input  logic [$clog2(DEPTH)-1:0]         head,
  input  logic [$clog2(DEPTH+1)-1:0]       count,
  input  logic [fqc_pkg::DATA_W-1:0]       value,
  input  logic [fqc_pkg::DATA_W-1:0]       rd_data,
  output logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [$clog2(DEPTH+1)-1:0]       rd_left,
  output logic                             cmp_pend,
  output logic                             wr_en,
  output logic [$clog2(DEPTH)-1:0]         wr_addr,
  output logic [fqc_pkg::DATA_W-1:0]       wr_data,
  output logic [$clog2(DEPTH+1)-1:0]       kept
);
  import fqc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;

  // survivor: compared entry differs from the cancel value
  assign wr_en   = cmp_pend && (rd_data != value);
  assign wr_addr = wr_ptr;
  assign wr_data = rd_data;
  assign rd_addr = rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      rd_left  <= '0;
      kept     <= '0;
      cmp_pend <= 1'b0;
    end else if (ctl.start) begin
      rd_ptr   <= head;
      wr_ptr   <= head;
      rd_left  <= count;
      kept     <= '0;
      cmp_pend <= 1'b0;
    end else begin
      if (ctl.rd_step) begin
        rd_ptr  <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        rd_left <= rd_left - 1'b1;
      end
      cmp_pend <= ctl.rd_step && ctl.cancel;
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        kept   <= kept + 1'b1;
      end
    end
  end

endmodule

>>> src/fifo_queue_with_cancel.sv
`timescale 1ns / 1ps

// Bounded queue of signed 32-bit values held in a circular buffer in one
// dual-port ram (one write and one registered read per cycle). Each input
// beat carries a command: enqueue, dequeue, head, list or cancel-by-value.
// Enqueue, dequeue and head each return one beat; list of n entries
// emits one beat per entry with tlast on the tail entry; cancel walks
// the n entries in turn: the walk reads one entry per
// cycle through the single read port, compares it against the value and
// writes survivors back toward the head through the write port. The block
// takes one command at a time; the finished result sits in an output
// register, so the next command is accepted while it waits. Errors (empty,
// full, not found) come back as a single beat with the status in tuser.
// Command codes 5 to 7 are dropped with no result. Occupancy carries the
// low 5 bits of the entry count after the command.

module fifo_queue_with_cancel #(
  parameter int DEPTH = fqc_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fqc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // cmd[2:0], value[34:3], zero
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fqc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // data[31:0], occupancy[36:32], zero
  output logic                               m_axis_tlast,
  output logic [fqc_pkg::ST_W-1:0]           m_axis_tuser    // status[1:0]
);
  import fqc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_FETCH   = 3'd2;
  localparam logic [2:0] S_HEAD    = 3'd3;
  localparam logic [2:0] S_LSTREAM = 3'd4;
  localparam logic [2:0] S_CANCEL  = 3'd5;
  localparam logic [2:0] S_CRES    = 3'd6;

  function automatic logic [OCC_W-1:0] to_occ(input logic [CW-1:0] c);
    logic [CW+OCC_W-1:0] x;
    x = {{OCC_W{1'b0}}, c};
    return x[OCC_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] to_data(input logic [CW-1:0] c);
    logic [CW+DATA_W-1:0] x;
    x = {{DATA_W{1'b0}}, c};
    return x[DATA_W-1:0];
  endfunction

  // input field split
  logic [CMD_W-1:0]  in_cmd;
  logic [DATA_W-1:0] in_value;
  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_value = s_axis_tdata[CMD_W+DATA_W-1:CMD_W];

  // control and queue state
  logic [2:0]        state, state_next;
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;

  // output register
  logic [DATA_W-1:0] out_data;
  logic [OCC_W-1:0]  out_occ;
  logic              out_free;
  logic              emit;
  logic [DATA_W-1:0] emit_data;
  logic [ST_W-1:0]   emit_status;
  logic              emit_last;
  logic [OCC_W-1:0]  emit_occ;

  // ram and walk unit
  walk_ctl_t         wctl;
  logic              enq_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     walk_rd_addr;
  logic [CW-1:0]     walk_rd_left;
  logic              walk_cmp_pend;
  logic              walk_wr_en;
  logic [AW-1:0]     walk_wr_addr;
  logic [DATA_W-1:0] walk_wr_data;
  logic [CW-1:0]     walk_kept;
  logic [CW-1:0]     removed;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign removed       = count - walk_kept;

  fqc_walk #(.DEPTH(DEPTH)) u_walk (
    .clk      (clk),
    .rst      (rst),
    .ctl      (wctl),
    .head     (head),
    .count    (count),
    .value    (value_r),
    .rd_data  (rd_data),
    .rd_addr  (walk_rd_addr),
    .rd_left  (walk_rd_left),
    .cmp_pend (walk_cmp_pend),
    .wr_en    (walk_wr_en),
    .wr_addr  (walk_wr_addr),
    .wr_data  (walk_wr_data),
    .kept     (walk_kept)
  );

  // the walk unit owns the write port during cancel, enqueue otherwise
  assign ram_we    = walk_wr_en || enq_we;
  assign ram_waddr = walk_wr_en ? walk_wr_addr : tail;
  assign ram_wdata = walk_wr_en ? walk_wr_data : value_r;

  fqc_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (wctl.rd_step),
    .raddr (walk_rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    wctl        = '0;
    enq_we      = 1'b0;
    emit        = 1'b0;
    emit_data   = '0;
    emit_status = ST_OK;
    emit_last   = 1'b1;
    emit_occ    = to_occ(count);

    case (state)
      S_IDLE: begin
        // unknown command codes are dropped without a result
        if (s_axis_tvalid && (in_cmd <= CMD_CANCEL)) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_r == CMD_ENQ) begin
          if (out_free) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (count == CW'(DEPTH)) begin
              emit_status = ST_FULL;
            end else begin
              enq_we     = 1'b1;
              tail_next  = (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
              count_next = count + 1'b1;
              emit_occ   = to_occ(count + 1'b1);
            end
          end
        end else if (count == '0) begin
          // every other command needs at least one entry
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_next  = S_IDLE;
          end
        end else begin
          wctl.start = 1'b1;
          state_next = (cmd_r == CMD_CANCEL) ? S_CANCEL : S_FETCH;
        end
      end

      S_FETCH: begin
        // first read for dequeue, head and list
        wctl.rd_step = 1'b1;
        state_next   = (cmd_r == CMD_LIST) ? S_LSTREAM : S_HEAD;
      end

      S_HEAD: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = rd_data;
          state_next = S_IDLE;
          if (cmd_r == CMD_DEQ) begin
            head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
            count_next = count - 1'b1;
            emit_occ   = to_occ(count - 1'b1);
          end
        end
      end

      S_LSTREAM: begin
        // rd_data holds the current entry until it is emitted
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rd_data;
          emit_last = (walk_rd_left == '0);
          if (walk_rd_left != '0) begin
            wctl.rd_step = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_CANCEL: begin
        wctl.cancel  = 1'b1;
        wctl.rd_step = (walk_rd_left != '0);
        if ((walk_rd_left == '0) && !walk_cmp_pend) begin
          state_next = S_CRES;
        end
      end

      S_CRES: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_occ   = to_occ(walk_kept);
          count_next = walk_kept;
          tail_next  = walk_wr_addr;
          state_next = S_IDLE;
          if (removed == '0) begin
            emit_status = ST_NOTFOUND;
          end else begin
            emit_data = to_data(removed);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data     <= emit_data;
      out_occ      <= emit_occ;
      m_axis_tlast <= emit_last;
      m_axis_tuser <= emit_status;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - DATA_W - OCC_W){1'b0}}, out_occ, out_data};

  // tail must always sit count entries past head
  logic [CW:0] tail_sum;
  logic [CW:0] tail_chk;
  assign tail_sum = (CW+1)'(head) + (CW+1)'(count);
  assign tail_chk = (tail_sum >= (CW+1)'(DEPTH)) ? tail_sum - (CW+1)'(DEPTH) : tail_sum;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_tail_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tail == AW'(tail_chk)))
    else $error("tail pointer out of step with head and count");

  a_walk_write: assert property (@(posedge clk) disable iff (rst)
    walk_wr_en |-> (state == S_CANCEL))
    else $error("compaction write outside cancel");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> m_axis_tlast)
    else $error("error beat without tlast");

endmodule

>>> bench/fifo_queue_with_cancel_tb.sv
`timescale 1ns / 1ps

module fifo_queue_with_cancel_tb;
  import fqc_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 440;
  localparam int LONG_HOLD    = 300;      // output hold-off, in cycles
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;       // a full list walk plus margin

  // codes the block must drop without a reply
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

  // random stimulus mixes
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] val;
  } queue_cmd_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    logic [ST_W-1:0]   status;
    logic              last;
    logic [OCC_W-1:0]  occ;
  } queue_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // cmd[2:0], value[34:3], zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // data[31:0], occupancy[36:32], zero
  logic                   m_axis_tlast;
  logic [ST_W-1:0]        m_axis_tuser;         // status[1:0]

  fifo_queue_with_cancel #(.DEPTH(DEPTH)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // commands waiting to go out, replies waiting to come back
  queue_cmd_t        cmd_backlog[$];
  queue_reply_t      queue_replies[$];
  // shadow copy of the queue contents, head at index 0
  logic [DATA_W-1:0] shadow_entries[$];

  int  total_items  = 0;
  int  items_taken  = 0;
  int  beats_seen   = 0;
  int  errors       = 0;
  int  full_hits    = 0;
  int  empty_hits   = 0;
  int  miss_hits    = 0;
  int  cancel_hits  = 0;
  int  dropped_cmds = 0;
  int  peak_fill    = 0;
  int  op_seen[8];
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  stall_left   = 0;
  int  hold_left    = 0;
  logic hold_arm    = 1'b0;
  logic in_took     = 1'b0;

  // apply one accepted command to the shadow queue and record its replies
  function automatic void apply_queue_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val);
    queue_reply_t      r;
    logic [DATA_W-1:0] kept[$];
    int                removed;
    op_seen[op]++;
    if (op > CMD_CANCEL) begin
      // dropped, no reply
      dropped_cmds++;
      return;
    end
    r.data   = '0;
    r.status = ST_OK;
    r.last   = 1'b1;
    if (op == CMD_ENQ) begin
      if (shadow_entries.size() >= DEPTH) begin
        r.status = ST_FULL;
        full_hits++;
      end else begin
        shadow_entries.push_back(val);
      end
    end else if (shadow_entries.size() == 0) begin
      r.status = ST_EMPTY;
      empty_hits++;
    end else if (op == CMD_DEQ) begin
      r.data = shadow_entries.pop_front();
    end else if (op == CMD_HEAD) begin
      r.data = shadow_entries[0];
    end else if (op == CMD_LIST) begin
      // one beat per entry, tlast only on the tail
      r.occ = OCC_W'(shadow_entries.size());
      for (int i = 0; i < shadow_entries.size(); i++) begin
        r.data = shadow_entries[i];
        r.last = (i == shadow_entries.size() - 1);
        queue_replies.push_back(r);
      end
      return;
    end else begin
      // cancel: keep survivors in order, report how many went
      foreach (shadow_entries[i]) begin
        if (shadow_entries[i] != val) kept.push_back(shadow_entries[i]);
      end
      removed = shadow_entries.size() - kept.size();
      shadow_entries = kept;
      if (removed == 0) begin
        r.status = ST_NOTFOUND;
        miss_hits++;
      end else begin
        r.data = removed;
        cancel_hits++;
      end
    end
    r.occ = OCC_W'(shadow_entries.size());
    if (shadow_entries.size() > peak_fill) peak_fill = shadow_entries.size();
    queue_replies.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    // lean on a small pool so cancels find matches
    case ($urandom_range(0, 9))
      0:          return 32'h8000_0000;
      1:          return 32'h7fff_ffff;
      2, 3, 4, 5: return $urandom_range(0, 5);
      default:    return $urandom();
    endcase
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] val);
    queue_cmd_t c;
    c.op  = op;
    c.val = val;
    cmd_backlog.push_back(c);
    total_items++;
  endtask

  // no idling near the end of the stimulus, and in some windows mid-run
  function automatic bit quiet_phase();
    return (cmd_backlog.size() < 60) || ((cycle_count / 400) % 5 == 4);
  endfunction

  // sender: a beat stays up until taken, with random idle bursts
  always @(negedge clk) begin
    queue_cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (s_axis_tvalid && !in_took) begin
      // beat still on offer
    end else if (send_gap != 0) begin
      send_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (!quiet_phase() && $urandom_range(0, 99) < 12) begin
      send_gap = $urandom_range(0, 12);
      s_axis_tvalid <= 1'b0;
    end else if (cmd_backlog.size() != 0) begin
      c = cmd_backlog.pop_front();
      s_axis_tdata  <= {{(IN_TDATA_W - CMD_W - DATA_W){1'b0}}, c.val, c.op};
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // long output hold-off, counted here, armed once from the stimulus
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_arm) begin
      hold_left = LONG_HOLD;
      hold_arm  = 1'b0;
    end
  end

  // receiver: random stall bursts, or the long hold-off
  always @(negedge clk) begin
    if (rst || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet_phase() && $urandom_range(0, 99) < 10) begin
      stall_left = $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // both handshakes seen at the rising edge: predict on input, check on output
  always @(posedge clk) begin
    queue_reply_t want;
    logic [DATA_W-1:0] got_data;
    logic [OCC_W-1:0]  got_occ;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = s_axis_tvalid && s_axis_tready;
      if (in_took) begin
        apply_queue_cmd(s_axis_tdata[CMD_W-1:0], s_axis_tdata[CMD_W +: DATA_W]);
        items_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        got_data = m_axis_tdata[DATA_W-1:0];
        got_occ  = m_axis_tdata[DATA_W +: OCC_W];
        if (queue_replies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected beat: data=%h status=%0d last=%b occ=%0d",
                     $realtime, got_data, m_axis_tuser, m_axis_tlast, got_occ);
        end else begin
          want = queue_replies.pop_front();
          if (got_data !== want.data || m_axis_tuser !== want.status ||
              m_axis_tlast !== want.last || got_occ !== want.occ) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] beat %0d: want data=%h status=%0d last=%b occ=%0d",
                       $realtime, beats_seen, want.data, want.status, want.last, want.occ);
              $display("    got data=%h status=%0d last=%b occ=%0d",
                       got_data, m_axis_tuser, m_axis_tlast, got_occ);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d commands taken, %0d replies owed",
               cycle_count, items_taken, total_items, queue_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int mix;
    int enq_pct;
    logic [CMD_W-1:0] op;
    int roll;

    // directed: every command on an empty queue, the dropped codes
    add_cmd(CMD_DEQ, 32'h0);
    add_cmd(CMD_HEAD, 32'h0);
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(CMD_CANCEL, 32'h0);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++) add_cmd(CMD_W'(c), $urandom());
    // fill to the brim with extremes and a duplicate, then one too many
    add_cmd(CMD_ENQ, 32'h8000_0000);
    add_cmd(CMD_ENQ, 32'h7fff_ffff);
    add_cmd(CMD_ENQ, 32'hffff_ffff);
    add_cmd(CMD_ENQ, 32'h0);
    add_cmd(CMD_ENQ, 32'h7fff_ffff);
    for (int i = 5; i < DEPTH; i++) add_cmd(CMD_ENQ, $urandom());
    add_cmd(CMD_ENQ, 32'h1234_5678);
    // full-length list, cancel with and without a match, dequeue
    add_cmd(CMD_HEAD, 32'h0);
    add_cmd(CMD_LIST, 32'h0);
    add_cmd(CMD_CANCEL, 32'h7fff_ffff);
    add_cmd(CMD_CANCEL, 32'h1234_5678);
    add_cmd(CMD_DEQ, 32'h0);

    // random: runs of 30 commands, each run leaning toward fill, drain or neither
    mix = MIX_FILL;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 30 == 0 && k != 0) mix = $urandom_range(MIX_FILL, MIX_EVEN);
      enq_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 20 : 42;
      if ($urandom_range(0, 99) < enq_pct) begin
        op = CMD_ENQ;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3)       op = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        else if (roll < 35) op = CMD_DEQ;
        else if (roll < 50) op = CMD_HEAD;
        else if (roll < 63) op = CMD_LIST;
        else                op = CMD_CANCEL;
      end
      add_cmd(op, pick_value());
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // part way in, stop draining the output so the block backs up
    wait (cmd_backlog.size() <= 300);
    @(negedge clk);
    hold_arm = 1'b1;

    wait (items_taken == total_items);
    while (queue_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands (enq %0d deq %0d head %0d list %0d cancel %0d dropped %0d)",
             items_taken, op_seen[CMD_ENQ], op_seen[CMD_DEQ], op_seen[CMD_HEAD],
             op_seen[CMD_LIST], op_seen[CMD_CANCEL], dropped_cmds);
    $display("%0d reply beats; full %0d, empty %0d, not found %0d, cancel hits %0d, peak fill %0d",
             beats_seen, full_hits, empty_hits, miss_hits, cancel_hits, peak_fill);
    if (errors == 0 && queue_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
